### design/assert_macros.svh
// Assertion macros shared by the euler rotation block.
// Each macro expects i_clk and i_rst_n to be visible where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define EUL_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("eul: implication check failed");

// Next-cycle implication, checked outside reset.
`define EUL_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("eul: next-cycle check failed");

`endif

### design/eul_pkg.sv
// Shared constants and types for the euler angle to rotation matrix block.
// No dependencies; imported by every module of the block.
`default_nettype none

package eul_pkg;

    // Field widths.
    localparam int ANGLE_W = 16;
    localparam int OUT_W   = 16;
    localparam int UANG_W  = 15;   // reduced angle, 0 .. 23039
    localparam int REM_W   = 13;   // remainder within a quadrant, 0 .. 5759
    localparam int QUAD_W  = 2;

    // Angles are counts of 1/64 degree.
    localparam int FULL_TURN    = 23040;
    localparam int QUARTER_TURN = 5760;

    // pi/2 in Q30 for building the sine table.
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    // Divisors of the odd Taylor terms: (2n)*(2n+1).
    localparam logic [63:0] TAYLOR_DIV [1:7] = '{64'd6, 64'd20, 64'd42, 64'd72,
                                                 64'd110, 64'd156, 64'd210};

    // Output format Q1.14.
    localparam int OUT_FRAC = 14;
    localparam int OUT_ONE  = 16384;
    localparam logic signed [OUT_W-1:0] OUT_ONE_S = 16'sd16384;

    // Default configuration.
    localparam int SINE_DEPTH_DEF = 1024;
    localparam int FRAC_BITS_DEF  = 14;

    // Pipeline organization.
    localparam int LANE_STAGES  = 7;
    localparam int MERGE_STAGES = 6;
    localparam int PIPE_STAGES  = LANE_STAGES + MERGE_STAGES;

    localparam int IN_DATA_W  = 3 * ANGLE_W;
    localparam int OUT_DATA_W = 9 * OUT_W;

    // Stage load enables and occupancy, handed from the controller to the datapath.
    typedef struct packed {
        logic [PIPE_STAGES-1:0] en;
        logic [PIPE_STAGES-1:0] vld;
    } t_pipe_ctl;

endpackage

`default_nettype wire

### design/eul_ctrl.sv
// Pipeline controller: stage occupancy bits and per-stage load enables.
// A stage loads when it is empty or when the stage after it loads. Uses eul_pkg.
`default_nettype none

module eul_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic                i_ready,
    output logic                o_ready,
    output logic                o_valid,
    output eul_pkg::t_pipe_ctl  o_ctl
);
    import eul_pkg::*;

    localparam int LAST = PIPE_STAGES - 1;
    localparam logic [PIPE_STAGES-1:0] ALL_ONES = '1;

    logic [PIPE_STAGES-1:0] r_valid;
    logic [PIPE_STAGES-1:0] n_valid;
    logic [PIPE_STAGES-1:0] w_en;

    // Stage k may load if the output is taken or any stage from k onward is empty.
    always_comb begin
        for (int k = 0; k < PIPE_STAGES; k++) begin
            w_en[k] = i_ready | ~(&(r_valid | ~(ALL_ONES << k)));
        end
    end

    always_comb begin
        n_valid = r_valid;
        if (w_en[0]) begin
            n_valid[0] = i_valid;
        end
        for (int k = 1; k < PIPE_STAGES; k++) begin
            if (w_en[k]) begin
                n_valid[k] = r_valid[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= n_valid;
        end
    end

    assign o_ready   = w_en[0];
    assign o_valid   = r_valid[LAST];
    assign o_ctl.en  = w_en;
    assign o_ctl.vld = r_valid;

    `include "assert_macros.svh"

    // Any empty slot in the pipe must let a new word in.
    `EUL_ASSERT_IMPL(a_ready_with_room, !(&r_valid), o_ready)
    // A result that is not taken stays in the output stage.
    `EUL_ASSERT_NEXT(a_result_held, r_valid[LAST] && !i_ready, r_valid[LAST])

endmodule

`default_nettype wire

### design/eul_lane.sv
// One angle lane: wraps the angle to a full turn and looks up its sine and cosine
// in a quarter-wave table built at elaboration. Uses eul_pkg and eul_ctrl enables.
`default_nettype none

module eul_lane #(
    parameter int SINE_TABLE_DEPTH = eul_pkg::SINE_DEPTH_DEF,
    parameter int FRAC_BITS        = eul_pkg::FRAC_BITS_DEF
) (
    input  logic                               i_clk,
    input  eul_pkg::t_pipe_ctl                 i_ctl,
    input  logic signed [eul_pkg::ANGLE_W-1:0] i_angle,
    output logic signed [FRAC_BITS+1:0]        o_sin,
    output logic signed [FRAC_BITS+1:0]        o_cos
);
    import eul_pkg::*;

    localparam int VW  = FRAC_BITS + 2;
    localparam int EW  = FRAC_BITS + 1;
    localparam int IW  = $clog2(SINE_TABLE_DEPTH + 1);
    localparam int NW  = $clog2((QUARTER_TURN - 1) * SINE_TABLE_DEPTH + QUARTER_TURN / 2 + 1);
    localparam int KSH = NW + 14;
    localparam int MW  = NW + 2;
    localparam int PRW = NW + MW;
    localparam logic [63:0] RECIP =
        ((64'd1 << KSH) + 64'(QUARTER_TURN) - 64'd1) / 64'(QUARTER_TURN);
    localparam int ENTRY_SH = 30 - FRAC_BITS;
    localparam logic [63:0] ENTRY_HALF = (64'd1 << ENTRY_SH) >> 1;
    localparam logic [IW-1:0] D_IDX = IW'(SINE_TABLE_DEPTH);
    localparam logic signed [16:0] TURN_S  = 17'sd23040;
    localparam logic signed [16:0] TURN2_S = 17'sd46080;

    // sin(k*pi/(2D)) from an odd Taylor series in Q30, rounded to FRAC_BITS.
    function automatic logic [EW-1:0] sine_entry(input int k);
        logic [63:0]        theta;
        logic [63:0]        t2;
        logic [63:0]        term;
        logic [63:0]        prod;
        logic signed [63:0] acc;
        theta = (64'(k) * HALF_PI_Q30 + 64'(SINE_TABLE_DEPTH / 2)) / 64'(SINE_TABLE_DEPTH);
        t2    = (theta * theta + (64'd1 << 29)) >> 30;
        term  = theta;
        acc   = signed'(theta);
        for (int n = 1; n <= 7; n++) begin
            prod = (term * t2 + (64'd1 << 29)) >> 30;
            term = (prod + TAYLOR_DIV[n] / 2) / TAYLOR_DIV[n];
            if (n % 2 == 1) begin
                acc = acc - signed'(term);
            end else begin
                acc = acc + signed'(term);
            end
        end
        if (acc < 0) begin
            acc = '0;
        end
        if (acc > signed'(64'd1 << 30)) begin
            acc = signed'(64'd1 << 30);
        end
        acc = (acc + signed'(ENTRY_HALF)) >>> ENTRY_SH;
        return EW'(acc);
    endfunction

    logic [EW-1:0] sine_rom [0:SINE_TABLE_DEPTH];

    for (genvar k = 0; k <= SINE_TABLE_DEPTH; k++) begin : g_rom
        assign sine_rom[k] = sine_entry(k);
    end

    // Stage 1: wrap into one turn.
    logic signed [16:0] n_wide;
    logic [UANG_W-1:0]  r_u;

    always_comb begin
        n_wide = 17'(i_angle);
        if (n_wide < 0) begin
            n_wide = (n_wide < -TURN_S) ? n_wide + TURN2_S : n_wide + TURN_S;
        end else if (n_wide >= TURN_S) begin
            n_wide = n_wide - TURN_S;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[0]) begin
            r_u <= n_wide[UANG_W-1:0];
        end
    end

    // Stage 2: quadrant and remainder. The cosine sits one quadrant ahead
    // with the same remainder.
    logic [QUAD_W-1:0] n_quad;
    logic [UANG_W-1:0] n_base;
    logic [QUAD_W-1:0] r_quad2;
    logic [REM_W-1:0]  r_rem;

    always_comb begin
        if (r_u >= UANG_W'(3 * QUARTER_TURN)) begin
            n_quad = 2'd3;
            n_base = UANG_W'(3 * QUARTER_TURN);
        end else if (r_u >= UANG_W'(2 * QUARTER_TURN)) begin
            n_quad = 2'd2;
            n_base = UANG_W'(2 * QUARTER_TURN);
        end else if (r_u >= UANG_W'(QUARTER_TURN)) begin
            n_quad = 2'd1;
            n_base = UANG_W'(QUARTER_TURN);
        end else begin
            n_quad = 2'd0;
            n_base = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[1]) begin
            r_quad2 <= n_quad;
            r_rem   <= REM_W'(r_u - n_base);
        end
    end

    // Stage 3: numerator of the rounded index, r*D + quarter/2.
    logic [QUAD_W-1:0] r_quad3;
    logic [NW-1:0]     r_num;

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[2]) begin
            r_quad3 <= r_quad2;
            r_num   <= NW'(r_rem) * NW'(SINE_TABLE_DEPTH) + NW'(QUARTER_TURN / 2);
        end
    end

    // Stage 4: divide by the quarter turn through an exact reciprocal.
    logic [QUAD_W-1:0] r_quad4;
    logic [PRW-1:0]    r_prod;

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[3]) begin
            r_quad4 <= r_quad3;
            r_prod  <= PRW'(r_num) * PRW'(RECIP);
        end
    end

    // Stage 5: mirror the index in odd quadrants and pick the signs.
    logic [IW-1:0] n_idx;
    logic [IW-1:0] r_sin_idx;
    logic [IW-1:0] r_cos_idx;
    logic          r_sin_neg5;
    logic          r_cos_neg5;

    assign n_idx = r_prod[KSH +: IW];

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[4]) begin
            r_sin_idx  <= r_quad4[0] ? D_IDX - n_idx : n_idx;
            r_cos_idx  <= r_quad4[0] ? n_idx : D_IDX - n_idx;
            r_sin_neg5 <= r_quad4[1];
            r_cos_neg5 <= r_quad4[1] ^ r_quad4[0];
        end
    end

    // Stage 6: table read, two ports.
    logic [EW-1:0] r_sin_mag;
    logic [EW-1:0] r_cos_mag;
    logic          r_sin_neg6;
    logic          r_cos_neg6;

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[5]) begin
            r_sin_mag  <= sine_rom[r_sin_idx];
            r_cos_mag  <= sine_rom[r_cos_idx];
            r_sin_neg6 <= r_sin_neg5;
            r_cos_neg6 <= r_cos_neg5;
        end
    end

    // Stage 7: apply the sign.
    logic signed [VW-1:0] r_sin;
    logic signed [VW-1:0] r_cos;

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[6]) begin
            r_sin <= r_sin_neg6 ? -VW'(r_sin_mag) : VW'(r_sin_mag);
            r_cos <= r_cos_neg6 ? -VW'(r_cos_mag) : VW'(r_cos_mag);
        end
    end

    assign o_sin = r_sin;
    assign o_cos = r_cos;

endmodule

`default_nettype wire

### design/eul_merge.sv
// Merge stage: combines the sines and cosines of the three lanes into the nine
// rotation matrix entries in Q1.14. Uses eul_pkg and the enables from eul_ctrl.
`default_nettype none

module eul_merge #(
    parameter int FRAC_BITS = eul_pkg::FRAC_BITS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  eul_pkg::t_pipe_ctl                    i_ctl,
    input  logic signed [FRAC_BITS+1:0]           i_sy,
    input  logic signed [FRAC_BITS+1:0]           i_cy,
    input  logic signed [FRAC_BITS+1:0]           i_sp,
    input  logic signed [FRAC_BITS+1:0]           i_cp,
    input  logic signed [FRAC_BITS+1:0]           i_sr,
    input  logic signed [FRAC_BITS+1:0]           i_cr,
    output logic [eul_pkg::OUT_DATA_W-1:0]        o_matrix
);
    import eul_pkg::*;

    localparam int VW  = FRAC_BITS + 2;
    localparam int PW  = 2 * VW;
    localparam int UP  = (FRAC_BITS < OUT_FRAC) ? OUT_FRAC - FRAC_BITS : 0;
    localparam int DN  = (FRAC_BITS >= OUT_FRAC) ? FRAC_BITS - OUT_FRAC : 0;
    localparam int TW  = VW + UP + 1;
    localparam int E0  = LANE_STAGES;

    localparam logic signed [PW-1:0] P_ONE    = PW'(1);
    localparam logic signed [PW-1:0] P_HALF   = P_ONE <<< (FRAC_BITS - 1);
    localparam logic signed [PW-1:0] P_UNIT   = P_ONE <<< FRAC_BITS;
    localparam logic signed [VW:0]   S_UNIT   = (VW+1)'(1) <<< FRAC_BITS;
    localparam logic signed [TW-1:0] T_ONE    = TW'(1);
    localparam logic signed [TW-1:0] T_HALF   = (T_ONE <<< DN) >>> 1;
    localparam logic signed [TW-1:0] T_LIMIT  = TW'(OUT_ONE);

    typedef logic signed [VW-1:0] t_val;
    typedef logic signed [PW-1:0] t_prod;

    // Round to nearest with ties away from zero, then clamp to +-1.0.
    function automatic t_val fmul_fix(input t_prod p);
        t_prod s;
        s = p + P_HALF;
        if (p < 0) begin
            s = s - P_ONE;
        end
        s = s >>> FRAC_BITS;
        if (s > P_UNIT) begin
            s = P_UNIT;
        end else if (s < -P_UNIT) begin
            s = -P_UNIT;
        end
        return VW'(s);
    endfunction

    function automatic t_val clamp_sum(input logic signed [VW:0] s);
        logic signed [VW:0] c;
        c = s;
        if (c > S_UNIT) begin
            c = S_UNIT;
        end else if (c < -S_UNIT) begin
            c = -S_UNIT;
        end
        return VW'(c);
    endfunction

    // Requantize to Q1.14 and clamp.
    function automatic logic signed [OUT_W-1:0] to_out(input t_val v);
        logic signed [TW-1:0] s;
        s = TW'(v) <<< UP;
        s = s + T_HALF;
        if ((v < 0) && (DN > 0)) begin
            s = s - T_ONE;
        end
        s = s >>> DN;
        if (s > T_LIMIT) begin
            s = T_LIMIT;
        end else if (s < -T_LIMIT) begin
            s = -T_LIMIT;
        end
        return OUT_W'(s);
    endfunction

    // Stage 1: first products. Order: cy*sp, sy*sp, cy*cp, sy*cp, cp*sr,
    // cp*cr, sy*cr, sy*sr, cy*cr, cy*sr.
    t_prod r_p1 [0:9];
    t_val  r_sr1, r_cr1, r_sp1;

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[E0]) begin
            r_p1[0] <= i_cy * i_sp;
            r_p1[1] <= i_sy * i_sp;
            r_p1[2] <= i_cy * i_cp;
            r_p1[3] <= i_sy * i_cp;
            r_p1[4] <= i_cp * i_sr;
            r_p1[5] <= i_cp * i_cr;
            r_p1[6] <= i_sy * i_cr;
            r_p1[7] <= i_sy * i_sr;
            r_p1[8] <= i_cy * i_cr;
            r_p1[9] <= i_cy * i_sr;
            r_sr1   <= i_sr;
            r_cr1   <= i_cr;
            r_sp1   <= i_sp;
        end
    end

    // Stage 2: round the first products.
    t_val r_f2 [0:9];
    t_val r_sr2, r_cr2, r_sp2;

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[E0+1]) begin
            for (int i = 0; i < 10; i++) begin
                r_f2[i] <= fmul_fix(r_p1[i]);
            end
            r_sr2 <= r_sr1;
            r_cr2 <= r_cr1;
            r_sp2 <= r_sp1;
        end
    end

    // Stage 3: third factor of the triple products.
    t_prod r_p3 [0:3];
    t_val  r_f3 [0:7];
    t_val  r_sp3;

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[E0+2]) begin
            r_p3[0] <= r_f2[0] * r_sr2;
            r_p3[1] <= r_f2[0] * r_cr2;
            r_p3[2] <= r_f2[1] * r_sr2;
            r_p3[3] <= r_f2[1] * r_cr2;
            for (int i = 0; i < 8; i++) begin
                r_f3[i] <= r_f2[i+2];
            end
            r_sp3 <= r_sp2;
        end
    end

    // Stage 4: round the triple products.
    t_val r_g4 [0:3];
    t_val r_f4 [0:7];
    t_val r_sp4;

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[E0+3]) begin
            for (int i = 0; i < 4; i++) begin
                r_g4[i] <= fmul_fix(r_p3[i]);
            end
            for (int i = 0; i < 8; i++) begin
                r_f4[i] <= r_f3[i];
            end
            r_sp4 <= r_sp3;
        end
    end

    // Stage 5: sums for the four mixed entries, in row-major order.
    // r_f4 holds cy*cp, sy*cp, cp*sr, cp*cr, sy*cr, sy*sr, cy*cr, cy*sr.
    t_val r_e5 [0:8];

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[E0+4]) begin
            r_e5[0] <= r_f4[0];
            r_e5[1] <= clamp_sum((VW+1)'(r_g4[0]) - (VW+1)'(r_f4[4]));
            r_e5[2] <= clamp_sum((VW+1)'(r_g4[1]) + (VW+1)'(r_f4[5]));
            r_e5[3] <= r_f4[1];
            r_e5[4] <= clamp_sum((VW+1)'(r_g4[2]) + (VW+1)'(r_f4[6]));
            r_e5[5] <= clamp_sum((VW+1)'(r_g4[3]) - (VW+1)'(r_f4[7]));
            r_e5[6] <= -r_sp4;
            r_e5[7] <= r_f4[2];
            r_e5[8] <= r_f4[3];
        end
    end

    // Stage 6: output word.
    logic signed [OUT_W-1:0] r_out [0:8];

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[E0+5]) begin
            for (int i = 0; i < 9; i++) begin
                r_out[i] <= to_out(r_e5[i]);
            end
        end
    end

    for (genvar i = 0; i < 9; i++) begin : g_pack
        assign o_matrix[i*OUT_W +: OUT_W] = r_out[i];
    end

    `include "assert_macros.svh"

    // The diagonal corners never leave the Q1.14 unit range.
    `EUL_ASSERT_IMPL(a_m00_range, i_ctl.vld[PIPE_STAGES-1],
        (r_out[0] <= OUT_ONE_S) && (r_out[0] >= -OUT_ONE_S))
    `EUL_ASSERT_IMPL(a_m22_range, i_ctl.vld[PIPE_STAGES-1],
        (r_out[8] <= OUT_ONE_S) && (r_out[8] >= -OUT_ONE_S))

endmodule

`default_nettype wire

### design/euler_angles_to_rotation_matrix.sv
// Top level of the yaw-pitch-roll to rotation matrix converter.
// Instantiates eul_ctrl, three eul_lane copies and eul_merge; uses eul_pkg.
`default_nettype none

// Takes one word of yaw, pitch and roll (signed, 1/64 degree) per clock and returns the ZYX
// rotation matrix Rz(yaw)*Ry(pitch)*Rx(roll) as nine signed Q1.14 entries. Throughput is one
// word per cycle while the output is not stalled. The pipeline holds seven registered stages
// in each angle lane (wrap, quadrant split, index multiply, reciprocal multiply, mirror, sine
// table read, sign) and six in the matrix merge (two multiply and round passes, sums, output
// rounding). Each lane holds its own quarter-wave sine table of SINE_TABLE_DEPTH+1 entries,
// read at two addresses per cycle for the sine and the cosine. Stages hand data forward as
// soon as the next one is free, so a stalled output does not stop the input until every
// stage is full. The block has no state beyond the pipeline.
module euler_angles_to_rotation_matrix #(
    parameter int SINE_TABLE_DEPTH = eul_pkg::SINE_DEPTH_DEF,
    parameter int FRAC_BITS        = eul_pkg::FRAC_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // yaw_angle, pitch_angle, roll_angle
    input  logic [eul_pkg::IN_DATA_W-1:0]     s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // m00, m01, m02, m10, m11, m12, m20, m21, m22
    output logic [eul_pkg::OUT_DATA_W-1:0]    m_tdata
);
    import eul_pkg::*;

    t_pipe_ctl                w_ctl;
    logic signed [FRAC_BITS+1:0] w_sy, w_cy, w_sp, w_cp, w_sr, w_cr;

    eul_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_tvalid),
        .i_ready (m_tready),
        .o_ready (s_tready),
        .o_valid (m_tvalid),
        .o_ctl   (w_ctl)
    );

    eul_lane #(
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
        .FRAC_BITS        (FRAC_BITS)
    ) u_lane_yaw (
        .i_clk   (i_clk),
        .i_ctl   (w_ctl),
        .i_angle (s_tdata[0 +: ANGLE_W]),
        .o_sin   (w_sy),
        .o_cos   (w_cy)
    );

    eul_lane #(
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
        .FRAC_BITS        (FRAC_BITS)
    ) u_lane_pitch (
        .i_clk   (i_clk),
        .i_ctl   (w_ctl),
        .i_angle (s_tdata[ANGLE_W +: ANGLE_W]),
        .o_sin   (w_sp),
        .o_cos   (w_cp)
    );

    eul_lane #(
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
        .FRAC_BITS        (FRAC_BITS)
    ) u_lane_roll (
        .i_clk   (i_clk),
        .i_ctl   (w_ctl),
        .i_angle (s_tdata[2*ANGLE_W +: ANGLE_W]),
        .o_sin   (w_sr),
        .o_cos   (w_cr)
    );

    eul_merge #(
        .FRAC_BITS (FRAC_BITS)
    ) u_merge (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_ctl),
        .i_sy     (w_sy),
        .i_cy     (w_cy),
        .i_sp     (w_sp),
        .i_cp     (w_cp),
        .i_sr     (w_sr),
        .i_cr     (w_cr),
        .o_matrix (m_tdata)
    );

endmodule

`default_nettype wire

### dv/tb_top.sv
// Self-checking testbench for euler_angles_to_rotation_matrix (yaw, pitch, roll to ZYX matrix).
// Depends on eul_pkg and design sources; predicts most matrix words from its own sine table.
`timescale 1ns / 1ps

module tb_top;

    import eul_pkg::*;

    localparam int DEPTH          = SINE_DEPTH_DEF;
    localparam int FRAC           = FRAC_BITS_DEF;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 400;
    localparam int PHASE_WORDS    = 256;
    localparam int N_DIRECTED     = 21;
    localparam int N_PHASES       = 5;

    localparam logic [15:0] Q_ONE  = 16'h4000;
    localparam logic [15:0] Q_NEG  = 16'hC000;
    localparam logic [15:0] Q_ZERO = 16'h0000;

    // Matrix constants are packed m22 down to m00, so m00 lands in the lowest bits.
    localparam logic [OUT_DATA_W-1:0] MAT_IDENT =
        {Q_ONE, Q_ZERO, Q_ZERO, Q_ZERO, Q_ONE, Q_ZERO, Q_ZERO, Q_ZERO, Q_ONE};
    localparam logic [OUT_DATA_W-1:0] MAT_YAW_90 =
        {Q_ONE, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, Q_ONE, Q_ZERO, Q_NEG, Q_ZERO};
    localparam logic [OUT_DATA_W-1:0] MAT_YAW_180 =
        {Q_ONE, Q_ZERO, Q_ZERO, Q_ZERO, Q_NEG, Q_ZERO, Q_ZERO, Q_ZERO, Q_NEG};
    localparam logic [OUT_DATA_W-1:0] MAT_PITCH_90 =
        {Q_ZERO, Q_ZERO, Q_NEG, Q_ZERO, Q_ONE, Q_ZERO, Q_ONE, Q_ZERO, Q_ZERO};
    localparam logic [OUT_DATA_W-1:0] MAT_PITCH_M90 =
        {Q_ZERO, Q_ZERO, Q_ONE, Q_ZERO, Q_ONE, Q_ZERO, Q_NEG, Q_ZERO, Q_ZERO};
    localparam logic [OUT_DATA_W-1:0] MAT_ROLL_180 =
        {Q_NEG, Q_ZERO, Q_ZERO, Q_ZERO, Q_NEG, Q_ZERO, Q_ZERO, Q_ZERO, Q_ONE};

    typedef struct packed {
        logic signed [ANGLE_W-1:0] roll;
        logic signed [ANGLE_W-1:0] pitch;
        logic signed [ANGLE_W-1:0] yaw;
    } t_angles;

    typedef struct packed {
        logic                  typed;
        logic [OUT_DATA_W-1:0] want;
        t_angles               ang;
    } t_row;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    // yaw_angle, pitch_angle, roll_angle
    logic [IN_DATA_W-1:0]  s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    // m00, m01, m02, m10, m11, m12, m20, m21, m22
    logic [OUT_DATA_W-1:0] m_tdata;

    longint                sine_lut [0:DEPTH];
    logic [OUT_DATA_W-1:0] pending_mats [$];
    t_row                  directed [N_DIRECTED];
    int                    send_idle_pct;
    int                    rx_stall_pct;
    bit                    hold_trigger;
    int                    hold_left;
    int                    err_cnt;
    int                    words_sent;
    int                    mats_checked;
    int                    idle_cycles;

    euler_angles_to_rotation_matrix i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Round to nearest with ties away from zero, then drop s fraction bits.
    function automatic longint rnd_shift(longint v, int s);
        longint unsigned mag;
        bit              neg;
        neg = (v < 0);
        mag = neg ? longint'(-v) : longint'(v);
        if (s > 0)
            mag = (mag + (64'd1 << (s - 1))) >> s;
        return neg ? -longint'(mag) : longint'(mag);
    endfunction

    function automatic longint clip(longint v, longint lim);
        if (v > lim)
            return lim;
        if (v < -lim)
            return -lim;
        return v;
    endfunction

    // Quarter-wave entry k: odd Taylor series of sin in Q30, each term rounded.
    function automatic longint taylor_entry(int k);
        longint unsigned kk, theta, t2, term, p, d;
        longint          acc;
        kk    = k;
        theta = (kk * HALF_PI_Q30 + 64'(DEPTH / 2)) / 64'(DEPTH);
        t2    = (theta * theta + (64'd1 << 29)) >> 30;
        term  = theta;
        acc   = longint'(theta);
        for (int n = 1; n <= 7; n++) begin
            d    = 64'(2 * n) * 64'(2 * n + 1);
            p    = (term * t2 + (64'd1 << 29)) >> 30;
            term = (p + d / 2) / d;
            if (n % 2 == 1)
                acc = acc - longint'(term);
            else
                acc = acc + longint'(term);
        end
        if (acc < 0)
            acc = 0;
        if (acc > (64'sd1 <<< 30))
            acc = 64'sd1 <<< 30;
        return rnd_shift(acc, 30 - FRAC);
    endfunction

    function automatic int wrap_angle(logic signed [ANGLE_W-1:0] a);
        int v;
        v = a;
        v = v % FULL_TURN;
        if (v < 0)
            v += FULL_TURN;
        return v;
    endfunction

    function automatic longint lut_sine(int u);
        int     q, r, idx;
        longint v;
        q   = u / QUARTER_TURN;
        r   = u % QUARTER_TURN;
        idx = (r * DEPTH + QUARTER_TURN / 2) / QUARTER_TURN;
        if (q % 2 == 1)
            idx = DEPTH - idx;
        v = sine_lut[idx];
        return (q >= 2) ? -v : v;
    endfunction

    function automatic longint qmul(longint a, longint b);
        return clip(rnd_shift(a * b, FRAC), 64'sd1 <<< FRAC);
    endfunction

    function automatic logic [OUT_W-1:0] to_q14(longint v);
        longint o;
        if (FRAC >= OUT_FRAC)
            o = rnd_shift(v, FRAC - OUT_FRAC);
        else
            o = v * (64'sd1 <<< (OUT_FRAC - FRAC));
        o = clip(o, OUT_ONE);
        return o[OUT_W-1:0];
    endfunction

    function automatic logic [OUT_DATA_W-1:0] rotation_of(t_angles a);
        int                    uy, up, ur;
        longint                sy, cy, sp, cp, sr, cr, cysp, sysp, one;
        longint                m [9];
        logic [OUT_DATA_W-1:0] res;
        one  = 64'sd1 <<< FRAC;
        uy   = wrap_angle(a.yaw);
        up   = wrap_angle(a.pitch);
        ur   = wrap_angle(a.roll);
        sy   = lut_sine(uy);
        cy   = lut_sine((uy + QUARTER_TURN) % FULL_TURN);
        sp   = lut_sine(up);
        cp   = lut_sine((up + QUARTER_TURN) % FULL_TURN);
        sr   = lut_sine(ur);
        cr   = lut_sine((ur + QUARTER_TURN) % FULL_TURN);
        cysp = qmul(cy, sp);
        sysp = qmul(sy, sp);
        m[0] = qmul(cy, cp);
        m[1] = clip(qmul(cysp, sr) - qmul(sy, cr), one);
        m[2] = clip(qmul(cysp, cr) + qmul(sy, sr), one);
        m[3] = qmul(sy, cp);
        m[4] = clip(qmul(sysp, sr) + qmul(cy, cr), one);
        m[5] = clip(qmul(sysp, cr) - qmul(cy, sr), one);
        m[6] = -sp;
        m[7] = qmul(cp, sr);
        m[8] = qmul(cp, cr);
        for (int i = 0; i < 9; i++)
            res[i*OUT_W +: OUT_W] = to_q14(m[i]);
        return res;
    endfunction

    function automatic t_row row(int yaw, int pitch, int roll, bit typed = 1'b0,
                                 logic [OUT_DATA_W-1:0] want = '0);
        t_row t;
        t.ang.yaw   = 16'(yaw);
        t.ang.pitch = 16'(pitch);
        t.ang.roll  = 16'(roll);
        t.typed     = typed;
        t.want      = want;
        return t;
    endfunction

    // Mostly full-range angles, with extra weight on quadrant edges, wraps and extremes.
    function automatic logic signed [ANGLE_W-1:0] pick_angle();
        int sel;
        sel = $urandom_range(9);
        case (sel)
            0, 1, 2, 3, 4: return 16'($urandom);
            5, 6:          return 16'(int'($urandom_range(FULL_TURN)) - FULL_TURN / 2);
            7:             return 16'(int'($urandom_range(10)) * QUARTER_TURN - 5 * QUARTER_TURN
                                      + int'($urandom_range(4)) - 2);
            default: begin
                case ($urandom_range(3))
                    0:       return 16'sh8000;
                    1:       return 16'sh7FFF;
                    2:       return 16'sh0000;
                    default: return 16'shFFFF;
                endcase
            end
        endcase
    endfunction

    // Offers one angle word, with random gaps ahead of it, and books its matrix on acceptance.
    task automatic send_word(t_angles a, logic [OUT_DATA_W-1:0] want);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= a;
        @(posedge i_clk);
        while (!s_tready)
            @(posedge i_clk);
        pending_mats.push_back(want);
        words_sent++;
        @(negedge i_clk);
    endtask

    initial begin : rx
        bit rdy;
        m_tready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_trigger) begin
                hold_left    = HOLD_CYCLES;
                hold_trigger = 1'b0;
            end
            if (hold_left > 0) begin
                rdy = 1'b0;
                hold_left--;
            end else begin
                rdy = ($urandom_range(99) >= rx_stall_pct);
            end
            m_tready <= rdy;
        end
    end

    always @(posedge i_clk) begin : matrix_check
        logic [OUT_DATA_W-1:0] want;
        if (i_rst_n && m_tvalid && m_tready) begin
            if (pending_mats.size() == 0) begin
                $error("matrix word %h arrived with no angle word pending", m_tdata);
                err_cnt++;
            end else begin
                want = pending_mats.pop_front();
                for (int i = 0; i < 9; i++) begin
                    if (m_tdata[i*OUT_W +: OUT_W] !== want[i*OUT_W +: OUT_W]) begin
                        $error("m%0d%0d expected %0d got %0d", i / 3, i % 3,
                               $signed(want[i*OUT_W +: OUT_W]),
                               $signed(m_tdata[i*OUT_W +: OUT_W]));
                        err_cnt++;
                    end
                end
                mats_checked++;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : main
        int       idle_mix  [N_PHASES];
        int       stall_mix [N_PHASES];
        t_angles  a;
        i_rst_n       = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        send_idle_pct = 0;
        rx_stall_pct  = 0;
        hold_trigger  = 1'b0;
        hold_left     = 0;
        err_cnt       = 0;
        words_sent    = 0;
        mats_checked  = 0;
        idle_cycles   = 0;
        idle_mix      = '{0, 51, 0, 20, 0};
        stall_mix     = '{0, 0, 51, 20, 0};
        for (int k = 0; k <= DEPTH; k++)
            sine_lut[k] = taylor_entry(k);

        // Typed rows are the axis-aligned cases; the rest go through the predictor.
        directed = '{
            row(0, 0, 0, 1'b1, MAT_IDENT),
            row(5760, 0, 0, 1'b1, MAT_YAW_90),
            row(11520, 0, 0, 1'b1, MAT_YAW_180),
            row(0, 5760, 0, 1'b1, MAT_PITCH_90),
            row(0, -5760, 0, 1'b1, MAT_PITCH_M90),
            row(0, 0, 11520, 1'b1, MAT_ROLL_180),
            row(23040, 0, 0, 1'b1, MAT_IDENT),
            row(0, -23040, 0, 1'b1, MAT_IDENT),
            row(0, 0, -11520, 1'b1, MAT_ROLL_180),
            row(32767, 32767, 32767),
            row(-32768, -32768, -32768),
            row(32767, -32768, 0),
            row(2880, 2880, 2880),
            row(-1, 1, -1),
            row(5759, 5761, -5759),
            row(11519, -11519, 17279),
            row(2880, 5760, 2880),
            row(-2880, -5760, 8640),
            row(1000, -2000, 3000),
            row(-32768, 32767, -32768),
            row(21845, -21846, 12345)
        };

        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (directed[i])
            send_word(directed[i].ang,
                      directed[i].typed ? directed[i].want : rotation_of(directed[i].ang));

        for (int ph = 0; ph < N_PHASES; ph++) begin
            send_idle_pct = idle_mix[ph];
            rx_stall_pct  = stall_mix[ph];
            // The last mix holds the output off long enough to back the pipeline up.
            if (ph == N_PHASES - 1)
                hold_trigger = 1'b1;
            for (int n = 0; n < PHASE_WORDS; n++) begin
                a.yaw   = pick_angle();
                a.pitch = pick_angle();
                a.roll  = pick_angle();
                send_word(a, rotation_of(a));
            end
        end
        s_tvalid <= 1'b0;
        rx_stall_pct = 0;

        while (pending_mats.size() != 0)
            @(posedge i_clk);
        repeat (PIPE_STAGES + 10) @(posedge i_clk);

        $display("summary: %0d angle words in, %0d matrix words compared", words_sent,
                 mats_checked);
        $display("summary: directed axis cases, four idle and stall mixes, one long output hold");
        if (err_cnt == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

### files.f
+incdir+design
design/eul_pkg.sv
design/eul_ctrl.sv
design/eul_lane.sv
design/eul_merge.sv
design/euler_angles_to_rotation_matrix.sv
dv/tb_top.sv
